// ===== rtl/mfre_pkg.sv =====
`default_nettype none
package mfre_pkg;

    localparam int WIDTH = 200;
    localparam int HEIGHT = 200;
    localparam int STRIDE = (WIDTH + 7) / 8;
    localparam int FB_BYTES = STRIDE * HEIGHT;
    localparam int ADDR_W = $clog2(FB_BYTES);

    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_PIXEL = 3'd1;
    localparam logic [2:0] REQ_LINE = 3'd2;
    localparam logic [2:0] REQ_FILL = 3'd3;
    localparam logic [2:0] REQ_OUTLINE = 3'd4;
    localparam logic [2:0] REQ_READ = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_LINE,
        ST_FILL,
        ST_OUT_H,
        ST_OUT_V,
        ST_READ,
        ST_READ_WAIT,
        ST_RMW_WAIT,
        ST_RMW_WRITE,
        ST_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic wipe_start;
        logic wipe_step;
        logic line_start;
        logic line_step;
        logic fill_start;
        logic fill_step;
        logic outh_start;
        logic outh_step;
        logic outv_start;
        logic outv_step;
        logic pix_read;
        logic pix_write;
        logic byte_read;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic wipe_last;
        logic line_last;
        logic fill_last;
        logic fill_empty;
        logic out_last;
        logic pix_valid;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/mono_framebuffer_raster_engine_top.sv =====
`default_nettype none
// 1bpp framebuffer raster engine, 200 by 200 pixels, 25 bytes a row
// slave channel: s_tvalid, s_tready, s_tdata carries one drawing request
// master channel: m_tvalid, m_tready, m_tdata carries one result per request
// requests: clear, set pixel, line, fill rectangle, outline, read byte
// each drawn pixel is a read-modify-write on the single-port frame memory
// via ST_RMW_WAIT and ST_RMW_WRITE; off-screen pixels get no write
// clear writes one byte a cycle
// m_tvalid rises after a read byte passes ST_READ, ST_READ_WAIT, ST_RESULT
// after reset the memory is swept to zero, with s_tready low
// one request is worked on at a time, s_tready low until it is finished
// on a stalled receiver the result register holds until taken; the next
// request is still taken, and its result waits until the register frees
module mono_framebuffer_raster_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type, x_start, y_start, x_end, y_end, rect_width, rect_height,
    // white, read_index, zero pad
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data, done_type, zero pad
    output logic [15:0]      m_tdata
);

    mfre_pkg::cmd_t cmd;
    mfre_pkg::stat_t stat;
    logic res_load;
    logic [7:0] rd_byte;
    logic [2:0] kind_reg;
    logic [2:0] done_reg;
    logic [7:0] data_reg;
    logic valid_reg;

    mfre_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(s_tvalid),
        .req_kind(s_tdata[2:0]),
        .res_free(!valid_reg),
        .stat(stat),
        .cmd(cmd),
        .req_ready(s_tready),
        .res_load(res_load)
    );

    mfre_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .req_kind(s_tdata[2:0]),
        .x_start(s_tdata[12:3]),
        .y_start(s_tdata[22:13]),
        .x_end(s_tdata[32:23]),
        .y_end(s_tdata[42:33]),
        .rect_width(s_tdata[51:43]),
        .rect_height(s_tdata[60:52]),
        .white(s_tdata[61]),
        .read_index(s_tdata[74:62]),
        .stat(stat),
        .rd_byte(rd_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (res_load) valid_reg <= 1'b1;
        else if (m_tready) valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) kind_reg <= s_tdata[2:0];
        if (res_load)
        begin
            done_reg <= kind_reg;
            data_reg <= (kind_reg == mfre_pkg::REQ_READ) ? rd_byte : 8'h00;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {5'b0, done_reg, data_reg};

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("request taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !m_tvalid) else $error("result overrun");

endmodule
`default_nettype wire

// ===== rtl/mfre_ctrl.sv =====
`default_nettype none
module mfre_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic [2:0]      req_kind,
    input  wire logic            res_free,
    input  wire mfre_pkg::stat_t stat,
    output mfre_pkg::cmd_t       cmd,
    output logic                 req_ready,
    output logic                 res_load
);

    mfre_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfre_pkg::ST_WIPE;
            ret_reg <= mfre_pkg::ST_IDLE;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            last_reg <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        last_next = last_reg;
        cmd = '0;
        req_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            mfre_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    priority case (req_kind)
                        mfre_pkg::REQ_CLEAR:
                        begin
                            cmd.wipe_start = 1'b1;
                            state_next = mfre_pkg::ST_WIPE;
                        end
                        mfre_pkg::REQ_PIXEL, mfre_pkg::REQ_LINE:
                        begin
                            cmd.line_start = 1'b1;
                            state_next = mfre_pkg::ST_LINE;
                        end
                        mfre_pkg::REQ_FILL:
                        begin
                            cmd.fill_start = 1'b1;
                            state_next = mfre_pkg::ST_FILL;
                        end
                        mfre_pkg::REQ_OUTLINE:
                        begin
                            cmd.outh_start = 1'b1;
                            state_next = mfre_pkg::ST_OUT_H;
                        end
                        mfre_pkg::REQ_READ: state_next = mfre_pkg::ST_READ;
                        default: state_next = mfre_pkg::ST_RESULT;
                    endcase
                end
            end
            mfre_pkg::ST_WIPE:
            begin
                cmd.wipe_step = 1'b1;
                if (stat.wipe_last)
                begin
                    state_next = (ret_reg == mfre_pkg::ST_IDLE && !cmd.load &&
                                  last_reg == 1'b0) ? mfre_pkg::ST_IDLE
                                                    : mfre_pkg::ST_RESULT;
                    last_next = 1'b1;
                end
            end
            mfre_pkg::ST_LINE, mfre_pkg::ST_FILL, mfre_pkg::ST_OUT_H,
            mfre_pkg::ST_OUT_V:
            begin
                if (state_reg == mfre_pkg::ST_FILL && stat.fill_empty)
                    state_next = mfre_pkg::ST_RESULT;
                else if (stat.pix_valid)
                begin
                    cmd.pix_read = 1'b1;
                    ret_next = state_reg;
                    state_next = mfre_pkg::ST_RMW_WAIT;
                end
                else
                begin
                    unique case (state_reg)
                        mfre_pkg::ST_LINE:
                        begin
                            cmd.line_step = 1'b1;
                            if (stat.line_last) state_next = mfre_pkg::ST_RESULT;
                        end
                        mfre_pkg::ST_FILL:
                        begin
                            cmd.fill_step = 1'b1;
                            if (stat.fill_last) state_next = mfre_pkg::ST_RESULT;
                        end
                        mfre_pkg::ST_OUT_H:
                        begin
                            cmd.outh_step = 1'b1;
                            if (stat.out_last)
                            begin
                                cmd.outv_start = 1'b1;
                                state_next = mfre_pkg::ST_OUT_V;
                            end
                        end
                        default:
                        begin
                            cmd.outv_step = 1'b1;
                            if (stat.out_last) state_next = mfre_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            mfre_pkg::ST_RMW_WAIT: state_next = mfre_pkg::ST_RMW_WRITE;
            mfre_pkg::ST_RMW_WRITE:
            begin
                cmd.pix_write = 1'b1;
                state_next = ret_reg;
                unique case (ret_reg)
                    mfre_pkg::ST_LINE:
                    begin
                        cmd.line_step = 1'b1;
                        if (stat.line_last) state_next = mfre_pkg::ST_RESULT;
                    end
                    mfre_pkg::ST_FILL:
                    begin
                        cmd.fill_step = 1'b1;
                        if (stat.fill_last) state_next = mfre_pkg::ST_RESULT;
                    end
                    mfre_pkg::ST_OUT_H:
                    begin
                        cmd.outh_step = 1'b1;
                        if (stat.out_last)
                        begin
                            cmd.outv_start = 1'b1;
                            state_next = mfre_pkg::ST_OUT_V;
                        end
                    end
                    default:
                    begin
                        cmd.outv_step = 1'b1;
                        if (stat.out_last) state_next = mfre_pkg::ST_RESULT;
                    end
                endcase
            end
            mfre_pkg::ST_READ:
            begin
                cmd.byte_read = 1'b1;
                state_next = mfre_pkg::ST_READ_WAIT;
            end
            mfre_pkg::ST_READ_WAIT:
            begin
                cmd.byte_read = 1'b1;
                state_next = mfre_pkg::ST_RESULT;
            end
            mfre_pkg::ST_RESULT:
            begin
                cmd.byte_read = 1'b1;
                if (res_free)
                begin
                    res_load = 1'b1;
                    state_next = mfre_pkg::ST_IDLE;
                end
            end
            default: state_next = mfre_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/mfre_datapath.sv =====
`default_nettype none
module mfre_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mfre_pkg::cmd_t        cmd,
    input  wire logic [2:0]            req_kind,
    input  wire logic signed [9:0]     x_start,
    input  wire logic signed [9:0]     y_start,
    input  wire logic signed [9:0]     x_end,
    input  wire logic signed [9:0]     y_end,
    input  wire logic [8:0]            rect_width,
    input  wire logic [8:0]            rect_height,
    input  wire logic                  white,
    input  wire logic [12:0]           read_index,
    output mfre_pkg::stat_t            stat,
    output logic [7:0]                 rd_byte
);

    localparam int AW = mfre_pkg::ADDR_W;

    logic [7:0] mem [mfre_pkg::FB_BYTES];
    logic [7:0] q_reg;
    logic [AW-1:0] wipe_reg;
    logic white_reg;
    logic [12:0] ridx_reg;
    logic rd_ok_reg;
    logic wipe_en_reg;

    // walk position and bounds, 12 bit signed
    logic signed [11:0] cx_reg, cy_reg, x1_reg, y1_reg;
    logic signed [11:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [11:0] dx_reg, dy_reg, err_reg;
    logic sx_reg, sy_reg;
    logic pass_reg;

    logic signed [11:0] xs, ys, xe, ye, w, h;
    assign xs = 12'(x_start);
    assign ys = 12'(y_start);
    assign xe = 12'(x_end);
    assign ye = 12'(y_end);
    assign w = {3'b000, rect_width};
    assign h = {3'b000, rect_height};

    logic on_screen;
    logic [AW-1:0] paddr;
    logic [7:0] pmask;
    assign on_screen = cx_reg >= 0 && cx_reg < 12'(mfre_pkg::WIDTH) &&
                       cy_reg >= 0 && cy_reg < 12'(mfre_pkg::HEIGHT);
    assign paddr = AW'(cy_reg[8:0]) * AW'(mfre_pkg::STRIDE) + AW'(cx_reg[8:3]);
    assign pmask = 8'h80 >> cx_reg[2:0];

    logic signed [12:0] e2;
    assign e2 = {err_reg, 1'b0};

    assign stat.wipe_last = wipe_reg == AW'(mfre_pkg::FB_BYTES - 1);
    assign stat.line_last = cx_reg == x1_reg && cy_reg == y1_reg;
    assign stat.fill_last = cx_reg == xb_reg && cy_reg == yb_reg;
    assign stat.fill_empty = xa_reg > xb_reg || ya_reg > yb_reg;
    assign stat.out_last = cx_reg == xb_reg && cy_reg == yb_reg;
    assign stat.pix_valid = on_screen && !(pass_reg == 1'b0 && 1'b0);

    logic signed [11:0] fx0, fy0, fx1, fy1;
    always_comb
    begin
        fx0 = xs < 0 ? 12'sd0 : xs;
        fy0 = ys < 0 ? 12'sd0 : ys;
        fx1 = (xs + w > 12'(mfre_pkg::WIDTH)) ? 12'(mfre_pkg::WIDTH) - 12'sd1
                                               : xs + w - 12'sd1;
        fy1 = (ys + h > 12'(mfre_pkg::HEIGHT)) ? 12'(mfre_pkg::HEIGHT) - 12'sd1
                                                : ys + h - 12'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_reg <= '0;
            white_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load) white_reg <= white;
            if (cmd.wipe_start) wipe_reg <= '0;
            else if (cmd.wipe_step)
                wipe_reg <= stat.wipe_last ? '0 : wipe_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ridx_reg <= read_index;
            rd_ok_reg <= read_index < 13'(mfre_pkg::FB_BYTES);
            pass_reg <= 1'b0;
        end
        if (cmd.line_start)
        begin
            cx_reg <= xs;
            cy_reg <= ys;
            if (req_kind == mfre_pkg::REQ_PIXEL)
            begin
                x1_reg <= xs;
                y1_reg <= ys;
            end
            else
            begin
                x1_reg <= xe;
                y1_reg <= ye;
            end
            dx_reg <= xe > xs ? xe - xs : xs - xe;
            dy_reg <= ye > ys ? ys - ye : ye - ys;
            err_reg <= (xe > xs ? xe - xs : xs - xe) + (ye > ys ? ys - ye : ye - ys);
            sx_reg <= xs < xe;
            sy_reg <= ys < ye;
        end
        else if (cmd.line_step)
        begin
            if (e2 >= 13'(dy_reg) && e2 <= 13'(dx_reg))
                err_reg <= err_reg + dy_reg + dx_reg;
            else if (e2 >= 13'(dy_reg))
                err_reg <= err_reg + dy_reg;
            else if (e2 <= 13'(dx_reg))
                err_reg <= err_reg + dx_reg;
            if (e2 >= 13'(dy_reg)) cx_reg <= sx_reg ? cx_reg + 12'sd1 : cx_reg - 12'sd1;
            if (e2 <= 13'(dx_reg)) cy_reg <= sy_reg ? cy_reg + 12'sd1 : cy_reg - 12'sd1;
        end
        if (cmd.fill_start)
        begin
            xa_reg <= fx0;
            ya_reg <= fy0;
            xb_reg <= fx1;
            yb_reg <= fy1;
            cx_reg <= fx0;
            cy_reg <= fy0;
        end
        else if (cmd.fill_step)
        begin
            if (cx_reg == xb_reg)
            begin
                cx_reg <= xa_reg;
                cy_reg <= cy_reg + 12'sd1;
            end
            else cx_reg <= cx_reg + 12'sd1;
        end
        if (cmd.outh_start)
        begin
            // horizontal edges: top then bottom per column
            xa_reg <= xs;
            xb_reg <= xs + w - 12'sd1;
            ya_reg <= ys;
            yb_reg <= ys + h - 12'sd1;
            cx_reg <= xs;
            cy_reg <= ys;
            pass_reg <= 1'b0;
            if (w == 0 || h == 0)
            begin
                cx_reg <= 12'sh800;
                cy_reg <= 12'sh800;
                xb_reg <= 12'sh800;
                yb_reg <= 12'sh800;
                ya_reg <= 12'sh800;
                xa_reg <= 12'sh800;
            end
        end
        else if (cmd.outh_step)
        begin
            if (cy_reg == ya_reg && ya_reg != yb_reg) cy_reg <= yb_reg;
            else if (cy_reg == ya_reg || ya_reg == yb_reg)
            begin
                cy_reg <= ya_reg;
                cx_reg <= cx_reg + 12'sd1;
            end
            else
            begin
                cy_reg <= ya_reg;
                cx_reg <= cx_reg + 12'sd1;
            end
        end
        if (cmd.outv_start)
        begin
            pass_reg <= 1'b1;
            cx_reg <= xa_reg;
            cy_reg <= ya_reg;
        end
        else if (cmd.outv_step)
        begin
            if (cx_reg == xa_reg && xa_reg != xb_reg) cx_reg <= xb_reg;
            else
            begin
                cx_reg <= xa_reg;
                cy_reg <= cy_reg + 12'sd1;
            end
        end
    end

    // memory: one port, registered read
    logic [AW-1:0] maddr;
    logic mwe;
    logic [7:0] mwd;
    always_comb
    begin
        maddr = paddr;
        mwe = 1'b0;
        mwd = white_reg ? (q_reg | pmask) : (q_reg & ~pmask);
        if (cmd.wipe_step)
        begin
            maddr = wipe_reg;
            mwe = 1'b1;
            mwd = (white_reg && cmd.load == 1'b0 && wipe_en_reg) ? 8'hFF : 8'h00;
        end
        else if (cmd.byte_read) maddr = ridx_reg[AW-1:0];
        else if (cmd.pix_write) mwe = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) wipe_en_reg <= 1'b0;
        else if (cmd.wipe_start) wipe_en_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mwe) mem[maddr] <= mwd;
        q_reg <= mem[maddr];
    end

    assign rd_byte = rd_ok_reg ? q_reg : 8'h00;

endmodule
`default_nettype wire

// ===== tb/sv/mono_framebuffer_raster_engine_top_tb.sv =====
`default_nettype none
module mono_framebuffer_raster_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS = 750;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [2:0]        kind;
        logic signed [9:0] xs;
        logic signed [9:0] ys;
        logic signed [9:0] xe;
        logic signed [9:0] ye;
        logic [8:0]        w;
        logic [8:0]        h;
        logic              white;
        logic [12:0]       ridx;
        logic              known;
        logic [7:0]        want;
    } draw_req_t;

    typedef struct {
        logic [7:0] data;
        logic [2:0] kind;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    logic [7:0] shadow_fb [0:mfre_pkg::FB_BYTES-1];
    reply_t     pending_replies [$];
    int         errors;
    int         sent;
    int         checked;
    int         hold_cnt;
    longint     cycles;
    logic       calm;

    draw_req_t plan [0:25];

    mono_framebuffer_raster_engine_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic void paint_dot(input int x, input int y, input logic white);
        int idx;
        logic [7:0] bitmask;
        if (x < 0 || x >= mfre_pkg::WIDTH || y < 0 || y >= mfre_pkg::HEIGHT)
            return;
        idx = y * mfre_pkg::STRIDE + x / 8;
        bitmask = 8'h80 >> (x % 8);
        if (white)
            shadow_fb[idx] = shadow_fb[idx] | bitmask;
        else
            shadow_fb[idx] = shadow_fb[idx] & ~bitmask;
    endfunction

    function automatic void paint_block(input int x, input int y, input int w, input int h,
                                        input logic white);
        int x0;
        int y0;
        int x1;
        int y1;
        x0 = x < 0 ? 0 : x;
        y0 = y < 0 ? 0 : y;
        x1 = x + w > mfre_pkg::WIDTH ? mfre_pkg::WIDTH : x + w;
        y1 = y + h > mfre_pkg::HEIGHT ? mfre_pkg::HEIGHT : y + h;
        for (int j = y0; j < y1; j++)
            for (int i = x0; i < x1; i++)
                paint_dot(i, j, white);
    endfunction

    function automatic void paint_frame(input int x, input int y, input int w, input int h,
                                        input logic white);
        if (w <= 0 || h <= 0)
            return;
        for (int i = x; i <= x + w - 1; i++)
        begin
            paint_dot(i, y, white);
            paint_dot(i, y + h - 1, white);
        end
        for (int i = y; i <= y + h - 1; i++)
        begin
            paint_dot(x, i, white);
            paint_dot(x + w - 1, i, white);
        end
    endfunction

    function automatic void paint_stroke(input int x0, input int y0, input int x1, input int y1,
                                         input logic white);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        dx = x1 > x0 ? x1 - x0 : x0 - x1;
        dy = y1 > y0 ? y0 - y1 : y1 - y0;
        sx = x0 < x1 ? 1 : -1;
        sy = y0 < y1 ? 1 : -1;
        err = dx + dy;
        forever
        begin
            paint_dot(x0, y0, white);
            if (x0 == x1 && y0 == y1)
                break;
            e2 = 2 * err;
            if (e2 >= dy)
            begin
                err += dy;
                x0 += sx;
            end
            if (e2 <= dx)
            begin
                err += dx;
                y0 += sy;
            end
        end
    endfunction

    function automatic logic [7:0] apply_request(input draw_req_t r);
        logic [7:0] rd;
        rd = 8'h00;
        case (r.kind)
            mfre_pkg::REQ_CLEAR:
                for (int i = 0; i < mfre_pkg::FB_BYTES; i++)
                    shadow_fb[i] = r.white ? 8'hFF : 8'h00;
            mfre_pkg::REQ_PIXEL:
                paint_dot(int'(r.xs), int'(r.ys), r.white);
            mfre_pkg::REQ_LINE:
                paint_stroke(int'(r.xs), int'(r.ys), int'(r.xe), int'(r.ye), r.white);
            mfre_pkg::REQ_FILL:
                paint_block(int'(r.xs), int'(r.ys), int'(r.w), int'(r.h), r.white);
            mfre_pkg::REQ_OUTLINE:
                paint_frame(int'(r.xs), int'(r.ys), int'(r.w), int'(r.h), r.white);
            mfre_pkg::REQ_READ:
                if (int'(r.ridx) < mfre_pkg::FB_BYTES) rd = shadow_fb[r.ridx];
            default:
                rd = 8'h00;
        endcase
        return rd;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(11, 60);
    endfunction

    function automatic logic signed [9:0] near_coord();
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom());
        return 10'($urandom_range(0, 230)) - 10'sd15;
    endfunction

    function automatic draw_req_t random_request();
        draw_req_t r;
        int pick;
        r.xs = near_coord();
        r.ys = near_coord();
        r.xe = 10'($urandom());
        r.ye = 10'($urandom());
        r.w = 9'($urandom_range(0, 20));
        r.h = 9'($urandom_range(0, 20));
        r.white = 1'($urandom());
        r.ridx = 13'($urandom_range(0, mfre_pkg::FB_BYTES - 1));
        r.known = 1'b0;
        r.want = 8'h00;
        pick = $urandom_range(0, 199);
        if (pick < 2)
            r.kind = mfre_pkg::REQ_CLEAR;
        else if (pick < 50)
            r.kind = mfre_pkg::REQ_PIXEL;
        else if (pick < 85)
            r.kind = mfre_pkg::REQ_LINE;
        else if (pick < 115)
            r.kind = mfre_pkg::REQ_FILL;
        else if (pick < 145)
            r.kind = mfre_pkg::REQ_OUTLINE;
        else if (pick < 194)
            r.kind = mfre_pkg::REQ_READ;
        else
            r.kind = pick[0] ? REQ_SPARE_A : REQ_SPARE_B;
        if ($urandom_range(0, 7) != 0)
        begin
            r.xe = r.xs + 10'($urandom_range(0, 80)) - 10'sd40;
            r.ye = r.ys + 10'($urandom_range(0, 80)) - 10'sd40;
        end
        // one dimension may span its full range, the other stays thin
        case ($urandom_range(0, 11))
            0: begin r.w = 9'($urandom()); r.h = 9'($urandom_range(0, 3)); end
            1: begin r.h = 9'($urandom()); r.w = 9'($urandom_range(0, 3)); end
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            r.ridx = 13'($urandom());
        return r;
    endfunction

    task automatic push_request(input draw_req_t r);
        int gap;
        logic [7:0] rd;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {5'd0, r.ridx, r.white, r.h, r.w, r.ye, r.xe, r.ys, r.xs, r.kind};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        rd = apply_request(r);
        pending_replies.push_back('{r.known ? r.want : rd, r.kind});
        sent++;
        calm <= ((sent / 100) % 4) == 3;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (calm)
            m_tready <= 1'b1;
        else if (hold_cnt == 0)
        begin
            m_tready <= $urandom_range(0, 2) != 0;
            hold_cnt <= pick_gap();
        end
        else
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result with no request waiting: %h", m_tdata);
                errors++;
            end
            else
            begin
                reply_t e;
                e = pending_replies.pop_front();
                checked++;
                if (m_tdata[7:0] !== e.data)
                begin
                    $error("read_data expected %h actual %h", e.data, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[10:8] !== e.kind)
                begin
                    $error("done_type expected %0d actual %0d", e.kind, m_tdata[10:8]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("mono_framebuffer_raster_engine_top test failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_cnt = 0;
        cycles = 0;
        calm = 1'b0;
        errors = 0;
        sent = 0;
        checked = 0;
        for (int i = 0; i < mfre_pkg::FB_BYTES; i++)
            shadow_fb[i] = 8'h00;
        //  kind                    xs    ys    xe   ye    w    h  white ridx known want
        plan = '{
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0,    0, 1, 8'h00},
            '{mfre_pkg::REQ_CLEAR,     0,    0,   0,   0,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0,    0, 1, 8'hFF},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0, 4999, 1, 8'hFF},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0, 5000, 1, 8'h00},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 1, 8191, 1, 8'h00},
            '{mfre_pkg::REQ_CLEAR,     0,    0,   0,   0,   0,   0, 0,    0, 0, 8'h00},
            '{mfre_pkg::REQ_PIXEL,     0,    0,   0,   0,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0,    0, 1, 8'h80},
            '{mfre_pkg::REQ_PIXEL,   199,  199,   0,   0,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0, 4999, 1, 8'h01},
            '{mfre_pkg::REQ_PIXEL,  -512, -512,   0,   0,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_PIXEL,   511,  511,   0,   0,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_PIXEL,   200,   10,   0,   0,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_LINE,     10,   10,  10,  10,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_LINE,   -512, -512, 511, 511,   0,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_LINE,    190,    3,   5, 150,   0,   0, 0,    0, 0, 8'h00},
            '{mfre_pkg::REQ_FILL,     20,   30,   0,   0,   0,  50, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_FILL,     20,   30,   0,   0,  17,   9, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_OUTLINE,  40,   40,   0,   0,  30,   0, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_OUTLINE,  -5,  190,   0,   0,  30,  20, 1,    0, 0, 8'h00},
            '{REQ_SPARE_A,             3,    4,   5,   6,   7,   8, 1,   25, 1, 8'h00},
            '{REQ_SPARE_B,            -1,   -1,  -1,  -1, 511, 511, 1, 8191, 1, 8'h00},
            '{mfre_pkg::REQ_FILL,      0,    0,   0,   0, 511, 511, 1,    0, 0, 8'h00},
            '{mfre_pkg::REQ_FILL,   -512, -512,   0,   0, 511, 511, 0,    0, 0, 8'h00},
            '{mfre_pkg::REQ_READ,      0,    0,   0,   0,   0,   0, 0,  100, 0, 8'h00}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (plan[i])
            push_request(plan[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            push_request(random_request());
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d results never arrived", pending_replies.size());
            errors++;
        end
        $display("sent %0d requests (%0d from the table), %0d results checked",
                 sent, $size(plan), checked);
        $display("clears, pixels, lines, fills, outlines, reads, spare codes, off-screen too");
        if (errors == 0)
            $display("mono_framebuffer_raster_engine_top test passed");
        else
            $display("mono_framebuffer_raster_engine_top test failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== mono_framebuffer_raster_engine_top.f =====
rtl/mfre_pkg.sv
rtl/mfre_ctrl.sv
rtl/mfre_datapath.sv
rtl/mono_framebuffer_raster_engine_top.sv
tb/sv/mono_framebuffer_raster_engine_top_tb.sv
